// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL in this folder.
// No dependencies; the asserting module must have a port named clock and one named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== src/imu_ctf_pkg.sv =====
// Package for the IMU complementary tilt filter: payload types, widths, constants.
// Holds the CORDIC arctangent table; no dependencies.
`default_nettype none

package imu_ctf_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   localparam int IDX_W        = 5;    // index into the 32-entry arctangent table
   localparam int CNT_W        = 6;    // sequencer counter, longest pass is 48 bits
   localparam int TIME_W       = 48;
   localparam int RATE_W       = 32;
   localparam int PROD_W       = RATE_W + TIME_W;
   localparam int CD_W         = 52;   // CORDIC x/y
   localparam int ZQ_W         = 34;   // CORDIC angle, Q2.30 plus headroom
   localparam int INV_W        = 32;
   localparam int GAIN_W       = CD_W + INV_W;
   localparam int BLEND_W      = 17;
   localparam int BACC_W       = 52;
   localparam int ACC_Q24_W    = ZQ_W - 6;

   localparam logic signed [ZQ_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [31:0]       PI_Q24      = 32'sd52707179;
   localparam logic [INV_W-1:0]         INV_GAIN    = 32'h9B74_EDA8;
   localparam logic [BLEND_W-1:0]       ALPHA_ONE   = 17'd65536;
   localparam logic [BLEND_W-1:0]       ALPHA_RESET = 17'd64225;
   localparam logic [46:0]              DELTA_CAP   = 47'h4000_0000_0000;

   typedef struct packed {
      logic signed [31:0] gyro_rate_x;
      logic signed [31:0] gyro_rate_y;
      logic signed [31:0] gyro_rate_z;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic [TIME_W-1:0]  sample_time;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] angle_x;
      logic signed [31:0] angle_y;
      logic signed [31:0] angle_z;
      logic               saturated;
   } rsp_item_type;

   // atan(2^-i) in Q2.30
   function automatic logic signed [ZQ_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
      logic signed [ZQ_W-1:0] v;
      case (i)
         5'd0:    v = 34'sh0_3243_F6A8;
         5'd1:    v = 34'sh0_1DAC_6705;
         5'd2:    v = 34'sh0_0FAD_BAFC;
         5'd3:    v = 34'sh0_07F5_6EA6;
         5'd4:    v = 34'sh0_03FE_AB76;
         5'd5:    v = 34'sh0_01FF_D55B;
         5'd6:    v = 34'sh0_00FF_FAAA;
         5'd7:    v = 34'sh0_007F_FF55;
         5'd8:    v = 34'sh0_003F_FFEA;
         5'd9:    v = 34'sh0_001F_FFFD;
         5'd10:   v = 34'sh0_000F_FFFF;
         5'd11:   v = 34'sh0_0007_FFFF;
         5'd12:   v = 34'sh0_0003_FFFF;
         5'd13:   v = 34'sh0_0001_FFFF;
         5'd14:   v = 34'sh0_0000_FFFF;
         5'd15:   v = 34'sh0_0000_7FFF;
         5'd16:   v = 34'sh0_0000_3FFF;
         5'd17:   v = 34'sh0_0000_1FFF;
         5'd18:   v = 34'sh0_0000_0FFF;
         5'd19:   v = 34'sh0_0000_07FF;
         5'd20:   v = 34'sh0_0000_03FF;
         5'd21:   v = 34'sh0_0000_01FF;
         5'd22:   v = 34'sh0_0000_00FF;
         5'd23:   v = 34'sh0_0000_007F;
         5'd24:   v = 34'sh0_0000_003F;
         5'd25:   v = 34'sh0_0000_001F;
         5'd26:   v = 34'sh0_0000_000F;
         5'd27:   v = 34'sh0_0000_0008;
         5'd28:   v = 34'sh0_0000_0004;
         5'd29:   v = 34'sh0_0000_0002;
         5'd30:   v = 34'sh0_0000_0001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/imu_complementary_tilt_filter.sv =====
// Top level of the IMU complementary tilt filter: sequencer and bit-serial datapath.
// Depends on imu_ctf_pkg and assert_macros.svh.
`default_nettype none

// One request transfer carries one IMU sample; exactly one response transfer follows with
// the three Q8.24 angles and a saturation flag. The block works on one sample at a time:
// req_stall is high from the accepting edge until the result is loaded into the response
// register, and the next sample can be taken while that result still waits on rsp_stall.
// After the first, a sample passes through the bit-serial rate-by-time-step multiply
// (all three axes side by side, one time-step bit per cycle), the delta add and
// saturation, two 24-iteration CORDIC vectoring passes on one shared shift-add stage
// with a serial multiply by the CORDIC reciprocal gain between them, a serial blend
// multiply over the bits of alpha and the response load. The very first sample skips
// the gyro multiply and the blend. blend_weight is written through csr_wr_en/csr_wr_data
// by the user, who must do so only while the block is idle; the block does not enforce
// it. Values above 65536 act as 65536. There is no memory and no clearing pass after reset.

module imu_complementary_tilt_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  imu_ctf_pkg::req_item_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output imu_ctf_pkg::rsp_item_type         rsp_data,
   input  logic                              csr_wr_en,
   input  logic [imu_ctf_pkg::BLEND_W-1:0]   csr_wr_data
);
   import imu_ctf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_GYRO   = 8'b0000_0010,   // serial rate * dt
      ST_GAPPLY = 8'b0000_0100,   // add deltas, saturate, load first CORDIC pass
      ST_COR1   = 8'b0000_1000,   // atan2(ay, az)
      ST_GAIN   = 8'b0001_0000,   // radius * 1/K
      ST_COR2   = 8'b0010_0000,   // atan2(ax, radius)
      ST_BLEND  = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
   localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

   // control
   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       started_ff, started_in;
   logic [BLEND_W-1:0]         blend_weight_ff, blend_weight_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]          last_time_ff, last_time_in;

   // payload
   req_item_type               item_ff, item_in;
   rsp_item_type               rsp_data_ff, rsp_data_in;
   logic signed [31:0]         ang_x_ff, ang_x_in, ang_y_ff, ang_y_in, ang_z_ff, ang_z_in;
   logic                       clip_ff, clip_in;
   logic [TIME_W-1:0]          dt_sh_ff, dt_sh_in;
   logic                       dt_neg_ff, dt_neg_in;
   logic [PROD_W-1:0]          prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [PROD_W-1:0]          prod_z_ff, prod_z_in;
   logic signed [CD_W-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZQ_W-1:0]     cz_ff, cz_in;
   logic                       zero_ff, zero_in;
   logic signed [ZQ_W-1:0]     z1_ff, z1_in, xq_ff, xq_in;
   logic [CD_W-1:0]            mag_ff, mag_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [INV_W-1:0]           inv_sh_ff, inv_sh_in;
   logic [BLEND_W-1:0]         alpha_sh_ff, alpha_sh_in;
   logic signed [BACC_W-1:0]   bx_ff, bx_in, bz_ff, bz_in;

   // combinational
   logic                       req_xfer;
   logic [TIME_W-1:0]          du;
   logic [PROD_W-1:0]          prod_x_nx, prod_y_nx, prod_z_nx;
   logic signed [47:0]         dlt_x, dlt_y, dlt_z;
   logic [32:0]                sat_x, sat_y, sat_z;
   logic [IDX_W-1:0]           idx;
   logic signed [CD_W-1:0]     dx, dy, cx_nx, cy_nx;
   logic signed [ZQ_W-1:0]     cz_nx, zres;
   logic signed [CD_W-1:0]     pv_x, pv_y, pre_x, pre_y;
   logic signed [ZQ_W-1:0]     pre_z;
   logic                       pre_zero;
   logic [GAIN_W-1:0]          gain_nx;
   logic signed [ACC_Q24_W-1:0] acc_x, acc_z;
   logic signed [32:0]         diff_x, diff_z;
   logic signed [BACC_W-1:0]   bx_nx, bz_nx, bsum_x, bsum_z;

   function automatic logic [RATE_W-1:0] abs32(input logic signed [31:0] v);
      return v[31] ? RATE_W'(-v) : RATE_W'(v);
   endfunction

   // round to Q8.24 half up on the magnitude, cap at 2^46, apply sign
   function automatic logic signed [47:0] gyro_delta(input logic [PROD_W-1:0] p,
                                                     input logic neg);
      logic [PROD_W-1:0] rnd;
      logic [46:0]       q;
      rnd = p + PROD_W'(2048);
      if (rnd[PROD_W-1:12] > (PROD_W-12)'(DELTA_CAP)) q = DELTA_CAP;
      else q = rnd[58:12];
      return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   // {clip, value}
   function automatic logic [32:0] sat32(input logic signed [48:0] v);
      if (v > SAT_HI) return {1'b1, 32'h7FFF_FFFF};
      if (v < SAT_LO) return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   // Q2.30 -> Q8.24, round by +32 then floor shift
   function automatic logic signed [ACC_Q24_W-1:0] q30_to_q24(input logic signed [ZQ_W-1:0] v);
      logic signed [ZQ_W-1:0] s;
      s = v + ZQ_W'(32);
      return s[ZQ_W-1:6];
   endfunction

   function automatic logic signed [CD_W-1:0] scale_in(input logic signed [31:0] v);
      return $signed({{(CD_W-48){v[31]}}, v, 16'd0});
   endfunction

   assign req_xfer  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // gyro: one time-step bit per cycle, MSB first, three axes in parallel
   assign du = req_data.sample_time - last_time_ff;
   assign prod_x_nx = (prod_x_ff << 1)
                    + (dt_sh_ff[TIME_W-1] ? PROD_W'(abs32(item_ff.gyro_rate_x)) : '0);
   assign prod_y_nx = (prod_y_ff << 1)
                    + (dt_sh_ff[TIME_W-1] ? PROD_W'(abs32(item_ff.gyro_rate_y)) : '0);
   assign prod_z_nx = (prod_z_ff << 1)
                    + (dt_sh_ff[TIME_W-1] ? PROD_W'(abs32(item_ff.gyro_rate_z)) : '0);

   assign dlt_x = gyro_delta(prod_x_ff, item_ff.gyro_rate_x[31] ^ dt_neg_ff);
   assign dlt_y = gyro_delta(prod_y_ff, item_ff.gyro_rate_y[31] ^ dt_neg_ff);
   assign dlt_z = gyro_delta(prod_z_ff, item_ff.gyro_rate_z[31] ^ dt_neg_ff);

   // angle x takes -gz, y takes -gy, z takes +gx
   assign sat_x = sat32($signed({{17{ang_x_ff[31]}}, ang_x_ff}) - $signed({dlt_z[47], dlt_z}));
   assign sat_y = sat32($signed({{17{ang_y_ff[31]}}, ang_y_ff}) - $signed({dlt_y[47], dlt_y}));
   assign sat_z = sat32($signed({{17{ang_z_ff[31]}}, ang_z_ff}) + $signed({dlt_x[47], dlt_x}));

   // one CORDIC vectoring micro-rotation per cycle
   assign idx = cnt_ff[IDX_W-1:0];
   assign dx  = cy_ff >>> idx;
   assign dy  = cx_ff >>> idx;
   always_comb begin
      if (!cy_ff[CD_W-1] && (cy_ff != '0)) begin
         cx_nx = cx_ff + dx;
         cy_nx = cy_ff - dy;
         cz_nx = cz_ff + atan_q30(idx);
      end else begin
         cx_nx = cx_ff - dx;
         cy_nx = cy_ff + dy;
         cz_nx = cz_ff - atan_q30(idx);
      end
   end
   assign zres = zero_ff ? '0 : cz_nx;

   // radius times reciprocal gain, one constant bit per cycle
   assign gain_nx = (gain_ff << 1) + (inv_sh_ff[INV_W-1] ? GAIN_W'(mag_ff) : '0);

   // vector source and left-half-plane pre-rotation
   always_comb begin
      if (state_ff == ST_GAPPLY) begin
         pv_x = scale_in(item_ff.accel_z);
         pv_y = scale_in(item_ff.accel_y);
      end else begin
         pv_x = $signed(gain_nx[GAIN_W-1:INV_W]);
         pv_y = scale_in(item_ff.accel_x);
      end
      pre_zero = (pv_x == '0) && (pv_y == '0);
      if (pv_x[CD_W-1]) begin
         if (!pv_y[CD_W-1]) begin
            pre_x = pv_y;
            pre_y = -pv_x;
            pre_z = HALF_PI_Q30;
         end else begin
            pre_x = -pv_y;
            pre_y = pv_x;
            pre_z = -HALF_PI_Q30;
         end
      end else begin
         pre_x = pv_x;
         pre_y = pv_y;
         pre_z = '0;
      end
   end

   // blend: alpha*(old - acc) serially over alpha, plus acc*65536, round, >>16
   assign acc_z  = q30_to_q24(z1_ff);
   assign acc_x  = q30_to_q24((state_ff == ST_COR2) ? zres : xq_ff);
   assign diff_x = $signed({ang_x_ff[31], ang_x_ff}) - $signed({{5{acc_x[ACC_Q24_W-1]}}, acc_x});
   assign diff_z = $signed({ang_z_ff[31], ang_z_ff}) - $signed({{5{acc_z[ACC_Q24_W-1]}}, acc_z});
   assign bx_nx  = (bx_ff <<< 1) + (alpha_sh_ff[BLEND_W-1] ?
                   $signed({{(BACC_W-33){diff_x[32]}}, diff_x}) : BACC_W'(0));
   assign bz_nx  = (bz_ff <<< 1) + (alpha_sh_ff[BLEND_W-1] ?
                   $signed({{(BACC_W-33){diff_z[32]}}, diff_z}) : BACC_W'(0));
   assign bsum_x = bx_nx + ($signed({{(BACC_W-ACC_Q24_W){acc_x[ACC_Q24_W-1]}}, acc_x}) <<< 16)
                 + BACC_W'(32768);
   assign bsum_z = bz_nx + ($signed({{(BACC_W-ACC_Q24_W){acc_z[ACC_Q24_W-1]}}, acc_z}) <<< 16)
                 + BACC_W'(32768);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      started_in      = started_ff;
      blend_weight_in = csr_wr_en ? csr_wr_data : blend_weight_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      last_time_in    = last_time_ff;
      item_in         = item_ff;
      rsp_data_in     = rsp_data_ff;
      ang_x_in        = ang_x_ff;
      ang_y_in        = ang_y_ff;
      ang_z_in        = ang_z_ff;
      clip_in         = clip_ff;
      dt_sh_in        = dt_sh_ff;
      dt_neg_in       = dt_neg_ff;
      prod_x_in       = prod_x_ff;
      prod_y_in       = prod_y_ff;
      prod_z_in       = prod_z_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      cz_in           = cz_ff;
      zero_in         = zero_ff;
      z1_in           = z1_ff;
      xq_in           = xq_ff;
      mag_in          = mag_ff;
      gain_in         = gain_ff;
      inv_sh_in       = inv_sh_ff;
      alpha_sh_in     = alpha_sh_ff;
      bx_in           = bx_ff;
      bz_in           = bz_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               item_in      = req_data;
               last_time_in = req_data.sample_time;
               dt_neg_in    = du[TIME_W-1];
               dt_sh_in     = du[TIME_W-1] ? -du : du;
               prod_x_in    = '0;
               prod_y_in    = '0;
               prod_z_in    = '0;
               clip_in      = 1'b0;
               cnt_in       = '0;
               // first sample only records its timestamp on the gyro side
               state_in     = started_ff ? ST_GYRO : ST_GAPPLY;
            end
         end
         ST_GYRO: begin
            prod_x_in = prod_x_nx;
            prod_y_in = prod_y_nx;
            prod_z_in = prod_z_nx;
            dt_sh_in  = dt_sh_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TIME_W - 1)) state_in = ST_GAPPLY;
         end
         ST_GAPPLY: begin
            if (started_ff) begin
               ang_x_in = $signed(sat_x[31:0]);
               ang_y_in = $signed(sat_y[31:0]);
               ang_z_in = $signed(sat_z[31:0]);
               clip_in  = sat_x[32] | sat_y[32] | sat_z[32];
            end
            cx_in    = pre_x;
            cy_in    = pre_y;
            cz_in    = pre_z;
            zero_in  = pre_zero;
            cnt_in   = '0;
            state_in = ST_COR1;
         end
         ST_COR1: begin
            cx_in  = cx_nx;
            cy_in  = cy_nx;
            cz_in  = cz_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_ITERS - 1)) begin
               z1_in     = zres;
               // a zero vector has zero radius; a negative radius reads as zero
               mag_in    = (zero_ff || cx_nx[CD_W-1]) ? '0 : CD_W'(cx_nx);
               gain_in   = '0;
               inv_sh_in = INV_GAIN;
               cnt_in    = '0;
               state_in  = ST_GAIN;
            end
         end
         ST_GAIN: begin
            gain_in   = gain_nx;
            inv_sh_in = inv_sh_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(INV_W - 1)) begin
               cx_in    = pre_x;
               cy_in    = pre_y;
               cz_in    = pre_z;
               zero_in  = pre_zero;
               cnt_in   = '0;
               state_in = ST_COR2;
            end
         end
         ST_COR2: begin
            cx_in  = cx_nx;
            cy_in  = cy_nx;
            cz_in  = cz_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_ITERS - 1)) begin
               xq_in  = zres;
               cnt_in = '0;
               if (!started_ff) begin
                  // first accel sample sets the attitude outright
                  ang_x_in = 32'(acc_x);
                  ang_z_in = 32'(acc_z);
                  ang_y_in = PI_Q24;
                  state_in = ST_OUT;
               end else begin
                  alpha_sh_in = (blend_weight_ff > ALPHA_ONE) ? ALPHA_ONE : blend_weight_ff;
                  bx_in       = '0;
                  bz_in       = '0;
                  state_in    = ST_BLEND;
               end
            end
         end
         ST_BLEND: begin
            bx_in       = bx_nx;
            bz_in       = bz_nx;
            alpha_sh_in = alpha_sh_ff << 1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(BLEND_W - 1)) begin
               ang_x_in = $signed(bsum_x[47:16]);
               ang_z_in = $signed(bsum_z[47:16]);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.angle_x   = ang_x_ff;
               rsp_data_in.angle_y   = ang_y_ff;
               rsp_data_in.angle_z   = ang_z_ff;
               rsp_data_in.saturated = clip_ff;
               rsp_valid_in          = 1'b1;
               started_in            = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         started_ff      <= 1'b0;
         blend_weight_ff <= ALPHA_RESET;
         rsp_valid_ff    <= 1'b0;
         last_time_ff    <= '0;
         ang_x_ff        <= '0;
         ang_y_ff        <= '0;
         ang_z_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         started_ff      <= started_in;
         blend_weight_ff <= blend_weight_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_time_ff    <= last_time_in;
         ang_x_ff        <= ang_x_in;
         ang_y_ff        <= ang_y_in;
         ang_z_ff        <= ang_z_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
      clip_ff     <= clip_in;
      dt_sh_ff    <= dt_sh_in;
      dt_neg_ff   <= dt_neg_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      prod_z_ff   <= prod_z_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      zero_ff     <= zero_in;
      z1_ff       <= z1_in;
      xq_ff       <= xq_in;
      mag_ff      <= mag_in;
      gain_ff     <= gain_in;
      inv_sh_ff   <= inv_sh_in;
      alpha_sh_ff <= alpha_sh_in;
      bx_ff       <= bx_in;
      bz_ff       <= bz_in;
   end

`include "assert_macros.svh"

   `ASSERT_NEVER(a_started_sticky, $fell(started_ff), "started flag cleared outside reset")
   `ASSERT_CLK(a_rsp_from_out, $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT), "response loaded outside output state")
   `ASSERT_CLK(a_alpha_clamped, (state_ff == ST_BLEND && cnt_ff == '0) |-> (alpha_sh_ff <= ALPHA_ONE), "blend weight above one entered blend")

endmodule

`default_nettype wire

// ===== tb/tb_imu_complementary_tilt_filter.sv =====
// Self-checking testbench for the IMU complementary tilt filter.
// Depends on imu_ctf_pkg and the imu_complementary_tilt_filter RTL.
`default_nettype none

module tb_imu_complementary_tilt_filter;
   timeunit 1ns;
   timeprecision 1ps;
   import imu_ctf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [BLEND_W-1:0] csr_wr_data = '0;

   imu_complementary_tilt_filter DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Filter state mirrored by the predictor.
   longint tilt_x, tilt_y, tilt_z;
   longint unsigned prev_stamp;
   bit     gyro_seen, accel_seen;
   logic [BLEND_W-1:0] alpha_reg;

   req_item_type samples_pending[$];
   rsp_item_type angles_expected[$];
   int  fail_count = 0;
   int  stall_free = 0;    // cycles left in a stretch with no idling
   bit  hold_sender = 1'b0;
   int  quiet_cycles = 0;

   // Atan(2^-i) in Q2.30, same table the hardware uses.
   function automatic longint atan_step(int i);
      longint tbl[32] = '{
         64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
         64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
         64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
         64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
         64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
         64'h00000001, 64'h00000000};
      return tbl[i];
   endfunction

   // >>> on longint is an arithmetic (floor) shift
   function automatic longint clamp32(longint v, inout bit clip);
      if (v > 64'sd2147483647) begin
         clip = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clip = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // rate (Q16.16) * dt (2^-20 s) -> Q8.24, rounded half away, capped at 2^46
   function automatic longint rate_times_dt(longint rate, longint dt);
      bit neg;
      longint unsigned r, d, a, b, q;
      neg = (rate < 0) != (dt < 0);
      r = (rate < 0) ? -rate : rate;
      d = (dt < 0) ? -dt : dt;
      a = r * (d >> 24);
      b = r * (d & 64'hFFFFFF);
      if (a >= (64'd1 << 34)) q = 64'd1 << 46;
      else q = (a << 12) + ((b + 64'd2048) >> 12);
      if (q > (64'd1 << 46)) q = 64'd1 << 46;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // CORDIC vectoring: returns atan2(y, x) in Q2.30, radius times gain in mag
   function automatic longint cordic_atan2(longint x, longint y, output longint mag);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sd1686629713;
         end else begin
            x = -y; y = t; z = -64'sd1686629713;
         end
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      mag = x;
      return z;
   endfunction

   function automatic longint mix(longint old_v, longint acc_v, longint a);
      return (a * old_v + (65536 - a) * acc_v + 32768) >>> 16;
   endfunction

   function automatic rsp_item_type predict_angles(req_item_type s);
      rsp_item_type res;
      bit clip;
      longint du, dt, mag, zq, xq, a;
      longint unsigned m, rad;
      clip = 1'b0;
      if (!gyro_seen) begin
         gyro_seen = 1'b1;
      end else begin
         du = (s.sample_time - prev_stamp) & 64'hFFFF_FFFF_FFFF;
         dt = du[47] ? du - (64'sd1 <<< 48) : du;
         tilt_x = clamp32(tilt_x - rate_times_dt(s.gyro_rate_z, dt), clip);
         tilt_y = clamp32(tilt_y - rate_times_dt(s.gyro_rate_y, dt), clip);
         tilt_z = clamp32(tilt_z + rate_times_dt(s.gyro_rate_x, dt), clip);
      end
      prev_stamp = 64'(s.sample_time);
      zq = cordic_atan2(longint'(s.accel_z) * 65536, longint'(s.accel_y) * 65536, mag);
      m = (mag < 0) ? 0 : mag;
      rad = (m >> 32) * 64'h9B74EDA8 + (((m & 64'hFFFFFFFF) * 64'h9B74EDA8) >> 32);
      xq = cordic_atan2(longint'(rad), longint'(s.accel_x) * 65536, mag);
      if (!accel_seen) begin
         accel_seen = 1'b1;
         tilt_x = (xq + 32) >>> 6;
         tilt_z = (zq + 32) >>> 6;
         tilt_y = longint'(PI_Q24);
      end else begin
         a = (alpha_reg > ALPHA_ONE) ? 64'sd65536 : longint'(alpha_reg);
         tilt_x = mix(tilt_x, (xq + 32) >>> 6, a);
         tilt_z = mix(tilt_z, (zq + 32) >>> 6, a);
      end
      res.angle_x = tilt_x[31:0];
      res.angle_y = tilt_y[31:0];
      res.angle_z = tilt_z[31:0];
      res.saturated = clip;
      return res;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 255) - 128;
         3: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Mostly modest rates and accel with a small time step; one in four has extreme or random fields.
   function automatic req_item_type rand_sample(longint unsigned stamp);
      req_item_type s;
      if ($urandom_range(0, 3) == 0) begin
         s.gyro_rate_x = rand_field();
         s.gyro_rate_y = rand_field();
         s.gyro_rate_z = rand_field();
         s.accel_x = rand_field();
         s.accel_y = rand_field();
         s.accel_z = rand_field();
         s.sample_time = TIME_W'({$urandom, $urandom});
      end else begin
         s.gyro_rate_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         s.gyro_rate_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         s.gyro_rate_z = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         s.accel_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         s.accel_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         s.accel_z = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         s.sample_time = TIME_W'(stamp + $urandom_range(0, 1 << 14));
      end
      return s;
   endfunction

   // Driver: pops pending samples; a held payload stays put until transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            angles_expected.push_back(predict_angles(req_data));
         end
         if (samples_pending.size() > 0 && !hold_sender &&
             (stall_free > 0 || $urandom_range(0, 99) >= 28)) begin
            req_data  <= samples_pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare every response transfer against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (stall_free > 0) stall_free <= stall_free - 1;
         rsp_stall <= (stall_free == 0) && ($urandom_range(0, 99) < 28);
         if (rsp_valid && !rsp_stall) begin
            if (angles_expected.size() == 0) begin
               $error("response with no sample outstanding");
               fail_count++;
            end else begin
               want = angles_expected.pop_front();
               if (rsp_data.angle_x !== want.angle_x) begin
                  $error("angle_x: expected %0d, got %0d", want.angle_x, rsp_data.angle_x);
                  fail_count++;
               end
               if (rsp_data.angle_y !== want.angle_y) begin
                  $error("angle_y: expected %0d, got %0d", want.angle_y, rsp_data.angle_y);
                  fail_count++;
               end
               if (rsp_data.angle_z !== want.angle_z) begin
                  $error("angle_z: expected %0d, got %0d", want.angle_z, rsp_data.angle_z);
                  fail_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b",
                         want.saturated, rsp_data.saturated);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[imu_complementary_tilt_filter] ERROR");
         $finish;
      end
   end

   // Wait until the sender has emptied its queue and all results came back.
   task automatic drain_all();
      while (samples_pending.size() > 0 || req_valid || angles_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha(logic [BLEND_W-1:0] a);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      alpha_reg = a;
   endtask

   initial begin
      req_item_type s;
      longint unsigned stamp;
      logic [BLEND_W-1:0] alpha_list[5];
      alpha_list = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd64225};
      tilt_x = 0; tilt_y = 0; tilt_z = 0;
      prev_stamp = 0;
      gyro_seen = 0; accel_seen = 0;
      alpha_reg = ALPHA_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vector, first sample, extremes, backwards time, huge steps.
      stamp = 64'd1000;
      s = '0; s.sample_time = TIME_W'(stamp);
      samples_pending.push_back(s);                  // zero accel, first sample
      s.accel_z = 32'sh10000; s.sample_time = TIME_W'(stamp + 1024);
      samples_pending.push_back(s);
      s.accel_x = 32'sh7FFF_FFFF; s.accel_y = 32'sh8000_0000; s.accel_z = 32'sh8000_0000;
      s.sample_time = TIME_W'(stamp + 2048);
      samples_pending.push_back(s);
      s.accel_y = 32'sh7FFF_FFFF; s.accel_z = -32'sh10000;
      s.gyro_rate_x = 32'sh10000; s.gyro_rate_y = -32'sh10000; s.gyro_rate_z = 32'sh20000;
      s.sample_time = TIME_W'(stamp + 100);          // time goes backwards
      samples_pending.push_back(s);
      s.gyro_rate_x = 32'sh7FFF_FFFF; s.gyro_rate_y = 32'sh8000_0000;
      s.gyro_rate_z = 32'sh7FFF_FFFF;
      s.sample_time = 48'h7FFF_FFFF_FFFF;            // huge step, saturates
      samples_pending.push_back(s);
      s.sample_time = 48'hFFFF_FFFF_FFFF;            // largest negative step
      samples_pending.push_back(s);
      s.gyro_rate_x = 32'sh8000_0000; s.gyro_rate_z = 32'sh8000_0000;
      s.sample_time = 48'h0;
      samples_pending.push_back(s);
      s = '0; s.accel_x = -32'sh10000; s.accel_y = 32'sh1; s.sample_time = 48'h10;
      samples_pending.push_back(s);
      s.accel_x = 32'sh0; s.accel_y = -32'sh1; s.accel_z = -32'sh5; s.sample_time = 48'h20;
      samples_pending.push_back(s);
      drain_all();

      // Random phases, each under a different blend weight.
      stamp = 0;
      for (int p = 0; p < 5; p++) begin
         write_alpha(alpha_list[p]);
         for (int n = 0; n < 230; n++) begin
            s = rand_sample(stamp);
            stamp = 64'(s.sample_time);
            samples_pending.push_back(s);
         end
         if (p == 1) stall_free = 3000;
         if (p == 2) begin
            // let half go, then hold off until every result is back
            while (samples_pending.size() > 115) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || angles_expected.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_all();
      end

      if (fail_count == 0)
         $display("[imu_complementary_tilt_filter] OK");
      else
         $display("[imu_complementary_tilt_filter] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/imu_ctf_pkg.sv
src/imu_complementary_tilt_filter.sv
tb/tb_imu_complementary_tilt_filter.sv
